@@ src/bpl_pkg.sv @@
// ---------------------------------------------------------------------------
// bpl_pkg: shared types and constants for the bounded positional list
// Sizes, operation and status codes, and the command and status structs
// that pass between the controller and the cell chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpl_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FUNC_W   = 4;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 16;
  localparam int STAT_W   = 3;

  // operation codes carried by func
  typedef enum logic [FUNC_W-1:0] {
    F_INS_FRONT = 4'd0,
    F_INS_END   = 4'd1,
    F_INS_POS   = 4'd2,
    F_DEL_FRONT = 4'd3,
    F_DEL_END   = 4'd4,
    F_DEL_POS   = 4'd5,
    F_SEARCH    = 4'd6,
    F_SHOW      = 4'd7,
    F_SHOW_REV  = 4'd8,
    F_CLEAR     = 4'd9
  } func_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_OOB     = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  // whole-chain operation for the current cycle
  typedef enum logic [2:0] {
    CH_NOP,
    CH_INSERT,
    CH_REMOVE,
    CH_ROT_FWD,
    CH_ROT_REV
  } chain_op_t;

  // per-cell move
  typedef enum logic [1:0] {
    C_HOLD,
    C_LOAD,
    C_FROM_LEFT,
    C_FROM_RIGHT
  } cell_op_t;

  typedef struct packed {
    chain_op_t         op;
    logic [CNT_W-1:0]  idx;
    logic [CNT_W-1:0]  cnt;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] key;
  } chain_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] front;
    logic [DATA_W-1:0] back;
    logic              hit;
  } chain_stat_t;

endpackage

`default_nettype wire

@@ src/bpl_if.sv @@
// ---------------------------------------------------------------------------
// bpl_in_if / bpl_out_if: valid/ready channels of the positional list
// One interface per direction; source drives valid and payload, sink ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bpl_in_if;
  import bpl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] item_value;
  logic signed [POS_W-1:0]  position;

  modport source (output valid, func, item_value, position, input ready);
  modport sink   (input valid, func, item_value, position, output ready);
endinterface

interface bpl_out_if;
  import bpl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic                     found;
  logic signed [DATA_W-1:0] out_value;
  logic                     last;

  modport source (output valid, status, found, out_value, last, input ready);
  modport sink   (input valid, status, found, out_value, last, output ready);
endinterface

`default_nettype wire

@@ src/bpl_cell.sv @@
// ---------------------------------------------------------------------------
// bpl_cell: one storage cell of the list chain
// Holds one value, takes it from a neighbor or a load bus, and compares it
// against the search key.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpl_cell (
  input  wire                         clk,
  input  bpl_pkg::cell_op_t           op,
  input  wire [bpl_pkg::DATA_W-1:0]   left_val,
  input  wire [bpl_pkg::DATA_W-1:0]   right_val,
  input  wire [bpl_pkg::DATA_W-1:0]   load_val,
  input  wire [bpl_pkg::DATA_W-1:0]   key,
  input  wire                         live,
  output logic [bpl_pkg::DATA_W-1:0]  value,
  output logic                        match
);
  import bpl_pkg::*;

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;

  // next value select
  always_comb begin
    case (op)
      C_LOAD:       val_nxt = load_val;
      C_FROM_LEFT:  val_nxt = left_val;
      C_FROM_RIGHT: val_nxt = right_val;
      default:      val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign value = val_r;
  assign match = live && (val_r == key);

endmodule

`default_nettype wire

@@ src/bpl_chain.sv @@
// ---------------------------------------------------------------------------
// bpl_chain: row of list cells
// Turns one chain command into a move for each cell: open a gap, close a
// gap, or rotate the occupied part by one place. Also reports front, back
// and whether any occupied cell matches the key.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpl_chain (
  input  wire                  clk,
  input  bpl_pkg::chain_cmd_t  cmd,
  output bpl_pkg::chain_stat_t stat
);
  import bpl_pkg::*;

  logic [DATA_W-1:0] vals    [CAPACITY];
  cell_op_t          ops     [CAPACITY];
  logic [CAPACITY-1:0] hits;
  logic [CAPACITY-1:0] live;
  logic [DATA_W-1:0] load_bus;
  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  back_idx;

  assign cnt_m1   = cmd.cnt - CNT_W'(1);
  assign back_idx = cnt_m1[IDX_W-1:0];

  // load bus: new value on insert, wrap-around value on rotation
  always_comb begin
    case (cmd.op)
      CH_ROT_FWD: load_bus = vals[0];
      CH_ROT_REV: load_bus = vals[back_idx];
      default:    load_bus = cmd.value;
    endcase
  end

  // per-cell move decode
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ops[i]  = C_HOLD;
      live[i] = CNT_W'(i) < cmd.cnt;
      case (cmd.op)
        CH_INSERT: begin
          if (CNT_W'(i) == cmd.idx) begin
            ops[i] = C_LOAD;
          end else if (CNT_W'(i) > cmd.idx && CNT_W'(i) <= cmd.cnt) begin
            ops[i] = C_FROM_LEFT;
          end
        end
        CH_REMOVE: begin
          if (CNT_W'(i) >= cmd.idx && CNT_W'(i) < cnt_m1) begin
            ops[i] = C_FROM_RIGHT;
          end
        end
        CH_ROT_FWD: begin
          if (CNT_W'(i) < cnt_m1) begin
            ops[i] = C_FROM_RIGHT;
          end else if (CNT_W'(i) == cnt_m1) begin
            ops[i] = C_LOAD;
          end
        end
        CH_ROT_REV: begin
          if (i == 0) begin
            ops[i] = C_LOAD;
          end else if (CNT_W'(i) < cmd.cnt) begin
            ops[i] = C_FROM_LEFT;
          end
        end
        default: ops[i] = C_HOLD;
      endcase
    end
  end

  // the row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] lv;
    logic [DATA_W-1:0] rv;

    if (g == 0) begin : g_first
      assign lv = '0;
    end else begin : g_mid_l
      assign lv = vals[g-1];
    end

    if (g == CAPACITY - 1) begin : g_lastc
      assign rv = '0;
    end else begin : g_mid_r
      assign rv = vals[g+1];
    end

    bpl_cell u_cell (
      .clk       (clk),
      .op        (ops[g]),
      .left_val  (lv),
      .right_val (rv),
      .load_val  (load_bus),
      .key       (cmd.key),
      .live      (live[g]),
      .value     (vals[g]),
      .match     (hits[g])
    );
  end

  assign stat.front = vals[0];
  assign stat.back  = vals[back_idx];
  assign stat.hit   = |hits;

endmodule

`default_nettype wire

@@ src/bounded_positional_list.sv @@
// ---------------------------------------------------------------------------
// bounded_positional_list: bounded ordered list of signed 32-bit values
// Controller with element count, a row of cells, and an output register.
//
//   channel  | direction | payload
//   ---------+-----------+-----------------------------------------
//   in_ch    | sink      | func, item_value, position
//   out_ch   | source    | status, found, out_value, last
//
// Insert, delete and clear leave their result in the output register. A
// search first captures the key, then compares it in every cell at once.
// A show emits one element per cycle while out_ch is not stalled, the
// chain rotating by one place per emitted element.
// Reset clears the count and control; cell contents are left as they are.
// A new transaction is taken only with the controller idle and the output
// register empty or being read in that cycle; out_ch stalls hold the show.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_positional_list (
  input  wire       clk,
  input  wire       rst_n,
  bpl_in_if.sink    in_ch,
  bpl_out_if.source out_ch
);
  import bpl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHOW
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic              rev_r, rev_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;

  logic              ovalid_r, ovalid_nxt;
  logic [STAT_W-1:0] ostat_r, ostat_nxt;
  logic              ofound_r, ofound_nxt;
  logic [DATA_W-1:0] oval_r, oval_nxt;
  logic              olast_r, olast_nxt;

  chain_cmd_t        cmd;
  chain_stat_t       cst;

  logic              out_free;
  logic              accept;
  logic              full;
  logic              empty;
  logic [POS_W-1:0]  pos_u;
  logic [POS_W-1:0]  cnt_w;
  logic [POS_W-1:0]  pos_m1;
  logic              pos_low;
  logic              ins_oob;
  logic              del_oob;
  logic              emit;
  status_t           emit_st;

  assign out_free = !ovalid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_ch.valid && in_ch.ready;

  // position checks
  assign full    = count_r == CNT_W'(CAPACITY);
  assign empty   = count_r == '0;
  assign pos_u   = in_ch.position;
  assign cnt_w   = POS_W'(count_r);
  assign pos_m1  = pos_u - POS_W'(1);
  assign pos_low = pos_u[POS_W-1] || (pos_u == '0);
  assign ins_oob = pos_u > (cnt_w + POS_W'(1));
  assign del_oob = pos_u > cnt_w;

  bpl_chain u_chain (
    .clk  (clk),
    .cmd  (cmd),
    .stat (cst)
  );

  // operation control
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    rem_nxt    = rem_r;
    rev_nxt    = rev_r;
    key_nxt    = key_r;
    emit       = 1'b0;
    emit_st    = ST_OK;
    cmd.op     = CH_NOP;
    cmd.idx    = '0;
    cmd.cnt    = count_r;
    cmd.value  = in_ch.item_value;
    cmd.key    = key_r;

    ovalid_nxt = ovalid_r && !out_ch.ready;
    ostat_nxt  = ostat_r;
    ofound_nxt = ofound_r;
    oval_nxt   = oval_r;
    olast_nxt  = olast_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.func)
            F_INS_FRONT, F_INS_END: begin
              emit = 1'b1;
              if (full) begin
                emit_st = ST_FULL;
              end else begin
                cmd.op    = CH_INSERT;
                cmd.idx   = (in_ch.func == F_INS_FRONT) ? '0 : count_r;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            F_INS_POS: begin
              emit = 1'b1;
              if (pos_low) begin
                emit_st = ST_INVALID;
              end else if (ins_oob) begin
                emit_st = ST_OOB;
              end else if (full) begin
                emit_st = ST_FULL;
              end else begin
                cmd.op    = CH_INSERT;
                cmd.idx   = pos_m1[CNT_W-1:0];
                count_nxt = count_r + CNT_W'(1);
              end
            end
            F_DEL_FRONT, F_DEL_END: begin
              emit = 1'b1;
              if (empty) begin
                emit_st = ST_EMPTY;
              end else begin
                cmd.op    = (in_ch.func == F_DEL_FRONT) ? CH_REMOVE : CH_NOP;
                cmd.idx   = '0;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            F_DEL_POS: begin
              emit = 1'b1;
              if (empty) begin
                emit_st = ST_EMPTY;
              end else if (pos_low) begin
                emit_st = ST_INVALID;
              end else if (del_oob) begin
                emit_st = ST_OOB;
              end else begin
                cmd.op    = CH_REMOVE;
                cmd.idx   = pos_m1[CNT_W-1:0];
                count_nxt = count_r - CNT_W'(1);
              end
            end
            F_SEARCH: begin
              key_nxt   = in_ch.item_value;
              state_nxt = S_SEARCH;
            end
            F_SHOW, F_SHOW_REV: begin
              if (empty) begin
                emit    = 1'b1;
                emit_st = ST_EMPTY;
              end else begin
                rem_nxt   = count_r;
                rev_nxt   = in_ch.func == F_SHOW_REV;
                state_nxt = S_SHOW;
              end
            end
            F_CLEAR: begin
              emit      = 1'b1;
              count_nxt = '0;
            end
            default: emit = 1'b0;
          endcase
          // single-result transactions
          if (emit) begin
            ovalid_nxt = 1'b1;
            ostat_nxt  = emit_st;
            ofound_nxt = 1'b0;
            oval_nxt   = '0;
            olast_nxt  = 1'b1;
          end
        end
      end
      S_SEARCH: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ostat_nxt  = ST_OK;
          ofound_nxt = cst.hit;
          oval_nxt   = '0;
          olast_nxt  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SHOW: begin
        // emit one element and rotate it out of the way
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ostat_nxt  = ST_OK;
          ofound_nxt = 1'b0;
          oval_nxt   = rev_r ? cst.back : cst.front;
          olast_nxt  = rem_r == CNT_W'(1);
          cmd.op     = rev_r ? CH_ROT_REV : CH_ROT_FWD;
          rem_nxt    = rem_r - CNT_W'(1);
          if (rem_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      rem_r    <= '0;
      rev_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rem_r    <= rem_nxt;
      rev_r    <= rev_nxt;
      ovalid_r <= ovalid_nxt;
    end
    key_r    <= key_nxt;
    ostat_r  <= ostat_nxt;
    ofound_r <= ofound_nxt;
    oval_r   <= oval_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_ch.valid     = ovalid_r;
  assign out_ch.status    = ostat_r;
  assign out_ch.found     = ofound_r;
  assign out_ch.out_value = oval_r;
  assign out_ch.last      = olast_r;

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the bounded positional list
// Drives list operations over the valid/ready input channel, mirrors the
// list in a local queue to predict every result, and compares each result
// transaction field by field under random idling and backpressure.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bpl_pkg::*;

  localparam int CYCLE_LIMIT      = 500_000;
  localparam int RANDOM_ITEMS     = 400;
  localparam int QUIET_ITEMS      = 100;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 2 * CAPACITY + 8;
  localparam int FUNC_TOP         = (1 << FUNC_W) - 1;

  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0]  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0]  POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};

  typedef struct packed {
    status_t                  status;
    logic                     found;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } list_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bpl_in_if  in_if ();
  bpl_out_if out_if ();

  bounded_positional_list dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // mirror of the list contents, front first
  logic signed [DATA_W-1:0] list_mirror[$];
  list_result_t             results_due[$];

  int   error_count   = 0;
  logic in_gap_on     = 1'b0;
  logic out_stall_on  = 1'b0;
  logic long_hold_req = 1'b0;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void queue_result(status_t st, logic hit,
                                       logic signed [DATA_W-1:0] v, logic lst);
    list_result_t r;
    r.status = st;
    r.found  = hit;
    r.value  = v;
    r.last   = lst;
    results_due.push_back(r);
  endfunction

  // apply one accepted operation to the mirror and queue its results
  function automatic void apply_list_op(logic [FUNC_W-1:0] fn,
                                        logic signed [DATA_W-1:0] val,
                                        logic signed [POS_W-1:0] pos);
    int      n;
    int      i;
    status_t st;
    logic    hit;
    n   = list_mirror.size();
    st  = ST_OK;
    hit = 1'b0;
    case (fn)
      F_INS_FRONT: begin
        if (n >= CAPACITY) st = ST_FULL;
        else list_mirror.push_front(val);
      end
      F_INS_END: begin
        if (n >= CAPACITY) st = ST_FULL;
        else list_mirror.push_back(val);
      end
      F_INS_POS: begin
        // position is checked before fullness
        if (pos < 1) st = ST_INVALID;
        else if (pos > n + 1) st = ST_OOB;
        else if (n >= CAPACITY) st = ST_FULL;
        else list_mirror.insert(int'(pos) - 1, val);
      end
      F_DEL_FRONT: begin
        if (n == 0) st = ST_EMPTY;
        else void'(list_mirror.pop_front());
      end
      F_DEL_END: begin
        if (n == 0) st = ST_EMPTY;
        else void'(list_mirror.pop_back());
      end
      F_DEL_POS: begin
        // emptiness is checked before the position
        if (n == 0) st = ST_EMPTY;
        else if (pos < 1) st = ST_INVALID;
        else if (pos > n) st = ST_OOB;
        else list_mirror.delete(int'(pos) - 1);
      end
      F_SEARCH: begin
        for (i = 0; i < n; i++) begin
          if (list_mirror[i] == val) hit = 1'b1;
        end
      end
      F_SHOW, F_SHOW_REV: begin
        if (n == 0) begin
          queue_result(ST_EMPTY, 1'b0, '0, 1'b1);
        end else begin
          for (i = 0; i < n; i++) begin
            queue_result(ST_OK, 1'b0,
                         (fn == F_SHOW) ? list_mirror[i] : list_mirror[n-1-i],
                         (i == n - 1));
          end
        end
        return;
      end
      F_CLEAR: list_mirror.delete();
      default: return;  // unused codes are dropped silently
    endcase
    queue_result(st, hit, '0, 1'b1);
  endfunction

  // offer one transaction and wait until it is taken
  task automatic send_transaction(input logic [FUNC_W-1:0] fn,
                                  input logic signed [DATA_W-1:0] val,
                                  input logic signed [POS_W-1:0] pos);
    int gap;
    gap = (in_gap_on && $urandom_range(0, 5) == 0) ? int'($urandom_range(1, 11)) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid      <= 1'b1;
    in_if.func       <= fn;
    in_if.item_value <= val;
    in_if.position   <= pos;
    do @(posedge clk); while (!in_if.ready);
    apply_list_op(fn, val, pos);
  endtask

  // drop valid and wait for every outstanding result
  task automatic wait_results_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return DATA_W'(int'($urandom_range(0, 15)) - 8);
      1:       return $urandom_range(0, 1) ? DATA_MIN : DATA_MAX;
      default: return $urandom();
    endcase
  endfunction

  // mostly around the legal range, sometimes any 16-bit value
  function automatic logic signed [POS_W-1:0] pick_position(int n);
    if ($urandom_range(0, 9) < 8) return POS_W'($urandom_range(0, n + 2));
    return POS_W'($urandom());
  endfunction

  task automatic send_unused_func();
    send_transaction(FUNC_W'($urandom_range(int'(F_CLEAR) + 1, FUNC_TOP)),
                     pick_value(), pick_position(0));
  endtask

  task automatic send_random_op(input int ins_pct, input int del_pct);
    int                       n;
    int                       roll;
    int                       k;
    logic [FUNC_W-1:0]        fn;
    logic signed [DATA_W-1:0] val;
    logic signed [POS_W-1:0]  pos;
    n    = list_mirror.size();
    roll = $urandom_range(0, 99);
    val  = pick_value();
    pos  = pick_position(n);
    if (roll < ins_pct) begin
      case ($urandom_range(0, 2))
        0:       fn = F_INS_FRONT;
        1:       fn = F_INS_END;
        default: fn = F_INS_POS;
      endcase
    end else if (roll < ins_pct + del_pct) begin
      case ($urandom_range(0, 2))
        0:       fn = F_DEL_FRONT;
        1:       fn = F_DEL_END;
        default: fn = F_DEL_POS;
      endcase
    end else begin
      k = $urandom_range(0, 19);
      if (k < 8) begin
        fn = F_SEARCH;
        // on a non-empty list, half the searches look for a value that is present
        if (n > 0 && $urandom_range(0, 1) == 1) val = list_mirror[$urandom_range(0, n - 1)];
      end else if (k < 13) begin
        fn = F_SHOW;
      end else if (k < 18) begin
        fn = F_SHOW_REV;
      end else begin
        fn = F_CLEAR;
      end
    end
    send_transaction(fn, val, pos);
  endtask

  // deletes, shows and searches on an empty list, plus an unused code
  task automatic test_empty_list();
    in_gap_on    = 1'b1;
    out_stall_on = 1'b1;
    send_transaction(F_SHOW, '0, '0);
    send_transaction(F_SHOW_REV, '0, '0);
    send_transaction(F_DEL_FRONT, '0, '0);
    send_transaction(F_DEL_END, '0, '0);
    send_transaction(F_DEL_POS, '0, POS_MIN);
    send_transaction(F_SEARCH, '0, '0);
    send_transaction(FUNC_W'(FUNC_TOP), DATA_MAX, POS_MAX);
  endtask

  // value and position extremes, every insert and delete flavor
  task automatic test_edge_values();
    send_transaction(F_INS_END, DATA_MIN, '0);
    send_transaction(F_INS_FRONT, DATA_MAX, '0);
    send_transaction(F_INS_POS, '0, POS_W'(2));
    send_transaction(F_INS_POS, '1, POS_W'(4));
    send_transaction(F_INS_POS, 32'sh1234_5678, POS_W'(6));
    send_transaction(F_INS_POS, 32'sh1234_5678, '0);
    send_transaction(F_INS_POS, 32'sh1234_5678, POS_MIN);
    send_transaction(F_INS_POS, 32'sh1234_5678, POS_MAX);
    send_transaction(F_SEARCH, DATA_MIN, '0);
    send_transaction(F_SHOW, '0, '0);
    send_transaction(F_SHOW_REV, '0, '0);
    send_transaction(F_DEL_POS, '0, '0);
    send_transaction(F_DEL_POS, '0, POS_W'(5));
    send_transaction(F_DEL_POS, '0, POS_W'(2));
    send_transaction(F_DEL_FRONT, '0, '0);
    send_transaction(F_DEL_END, '0, '0);
    send_transaction(F_CLEAR, '0, '0);
    wait_results_drained();
  endtask

  // long receiver hold-off and random stalls while the list is filled past capacity
  task automatic test_full_under_backpressure();
    int i;
    long_hold_req = 1'b1;
    for (i = 0; i < CAPACITY + 2; i++) begin
      send_transaction((i % 2 == 0) ? F_INS_END : F_INS_FRONT, pick_value(), '0);
    end
    send_transaction(F_INS_POS, pick_value(), '0);
    send_transaction(F_INS_POS, pick_value(), POS_W'(CAPACITY + 1));
    send_transaction(F_INS_POS, pick_value(), POS_W'(CAPACITY + 2));
    send_transaction(F_SHOW, '0, '0);
    send_transaction(F_SHOW_REV, '0, '0);
    wait_results_drained();
  endtask

  // phases that grow, churn, shrink and again churn the list, with a full drain after each
  task automatic test_random_traffic(input int n_items);
    int phase;
    int sent;
    int ins_pct;
    int del_pct;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin ins_pct = 60; del_pct = 15; end
        1:       begin ins_pct = 35; del_pct = 35; end
        2:       begin ins_pct = 15; del_pct = 55; end
        default: begin ins_pct = 45; del_pct = 30; end
      endcase
      sent = 0;
      while (sent < n_items / 4) begin
        if ($urandom_range(0, 49) == 0) begin
          send_unused_func();
        end else begin
          send_random_op(ins_pct, del_pct);
          sent++;
        end
      end
      wait_results_drained();
    end
  endtask

  // closing stretch with no idling on either side
  task automatic test_quiet_tail(input int n_items);
    int sent;
    in_gap_on    = 1'b0;
    out_stall_on = 1'b0;
    for (sent = 0; sent < n_items; sent++) send_random_op(45, 30);
  endtask

  // result receiver: random stall bursts and the long hold-off
  initial begin : result_sink
    int held;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        for (held = 1; held < LONG_HOLD_CYCLES; held++) @(negedge clk);
      end else if (out_stall_on && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: status %0d found %0d out_value %0d last %0d",
               out_if.status, out_if.found, out_if.out_value, out_if.last);
        error_count++;
      end else begin
        want = results_due.pop_front();
        if (out_if.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_if.status);
          error_count++;
        end
        if (out_if.found !== want.found) begin
          $error("found mismatch: expected %0d, actual %0d", want.found, out_if.found);
          error_count++;
        end
        if (out_if.out_value !== want.value) begin
          $error("out_value mismatch: expected %0d, actual %0d", want.value,
                 out_if.out_value);
          error_count++;
        end
        if (out_if.last !== want.last) begin
          $error("last mismatch: expected %0d, actual %0d", want.last, out_if.last);
          error_count++;
        end
      end
    end
  end

  // watchdog
  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  initial begin : run
    in_if.valid      = 1'b0;
    in_if.func       = '0;
    in_if.item_value = '0;
    in_if.position   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_edge_values();
    test_full_under_backpressure();
    test_random_traffic(RANDOM_ITEMS - QUIET_ITEMS);
    test_quiet_tail(QUIET_ITEMS);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
